// ===== sv/block_length_decimal_reporter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Block length decimal reporter: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_LENGTH_DECIMAL_REPORTER_UNIT_DEFINES_SVH
`define BLOCK_LENGTH_DECIMAL_REPORTER_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define BLR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define BLR_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/blr_pkg.sv =====
// ----------------------------------------------------------------------------
// Block length decimal reporter: package
// Types and character constants shared by the control and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package blr_pkg;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_MARKER  = 8'h00;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_EMIT  = 5'b00100,
    S_NL    = 5'b01000,
    S_MARK  = 5'b10000
  } emit_state_e;

  typedef struct packed {
    logic start;
    logic marker;
  } emit_req_t;

endpackage

`default_nettype wire

// ===== sv/blr_dec_emit.sv =====
// ----------------------------------------------------------------------------
// Block length decimal reporter: decimal emitter
// Bit-serial binary to BCD conversion followed by one character beat per
// digit, leading zeros suppressed, then a newline; also sends the end marker.
// ----------------------------------------------------------------------------
`default_nettype none
`include "block_length_decimal_reporter_unit_defines.svh"

module blr_dec_emit
  import blr_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire emit_req_t              req_i,
  input  wire logic [COUNT_WIDTH-1:0] value_i,
  output logic                        busy_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [7:0]                  text_char_o,
  output logic                        line_last_o,
  output logic                        transmission_ended_o
);

  localparam int NDIG = ((COUNT_WIDTH * 1233) >> 12) + 1;
  localparam int BW   = 4 * NDIG;
  localparam int SCW  = $clog2(COUNT_WIDTH);
  localparam int DCW  = $clog2(NDIG + 1);
  localparam logic [SCW-1:0] SHIFT_LAST = SCW'(COUNT_WIDTH - 1);
  localparam logic [DCW-1:0] DIG_ALL    = DCW'(NDIG);
  localparam logic [DCW-1:0] DIG_ONE    = DCW'(1);

  emit_state_e            state_q, state_d;
  logic [COUNT_WIDTH-1:0] bin_q, bin_d;
  logic [BW-1:0]          bcd_q, bcd_d, bcd_adj;
  logic [SCW-1:0]         scnt_q, scnt_d;
  logic [DCW-1:0]         dleft_q, dleft_d;
  logic                   started_q, started_d;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             char_q, char_d;
  logic                   last_q, last_d;
  logic                   ended_q, ended_d;
  logic                   load;
  logic                   slot_free;
  logic [3:0]             top_digit;
  logic                   show;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign top_digit = bcd_q[BW-1 -: 4];
  assign show      = started_q || (top_digit != 4'd0) || (dleft_q == DIG_ONE);

  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    scnt_d    = scnt_q;
    dleft_d   = dleft_q;
    started_d = started_q;
    load      = 1'b0;
    char_d    = char_q;
    last_d    = last_q;
    ended_d   = ended_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          if (req_i.marker) begin
            state_d = S_MARK;
          end else begin
            bin_d   = value_i;
            bcd_d   = '0;
            scnt_d  = '0;
            state_d = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        bin_d  = {bin_q[COUNT_WIDTH-2:0], 1'b0};
        bcd_d  = {bcd_adj[BW-2:0], bin_q[COUNT_WIDTH-1]};
        scnt_d = scnt_q + SCW'(1);
        if (scnt_q == SHIFT_LAST) begin
          dleft_d   = DIG_ALL;
          started_d = 1'b0;
          state_d   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!show || slot_free) begin
          bcd_d   = {bcd_q[BW-5:0], 4'd0};
          dleft_d = dleft_q - DIG_ONE;
          if (show) begin
            load      = 1'b1;
            char_d    = CHAR_ZERO + {4'd0, top_digit};
            last_d    = 1'b0;
            ended_d   = 1'b0;
            started_d = 1'b1;
          end
          if (dleft_q == DIG_ONE) begin
            state_d = S_NL;
          end
        end
      end
      S_NL: begin
        if (slot_free) begin
          load    = 1'b1;
          char_d  = CHAR_NEWLINE;
          last_d  = 1'b1;
          ended_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_MARK: begin
        if (slot_free) begin
          load    = 1'b1;
          char_d  = CHAR_MARKER;
          last_d  = 1'b1;
          ended_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    scnt_q    <= scnt_d;
    dleft_q   <= dleft_d;
    started_q <= started_d;
    char_q    <= char_d;
    last_q    <= last_d;
    ended_q   <= ended_d;
  end

  assign busy_o               = (state_q != S_IDLE);
  assign out_valid_o          = out_valid_q;
  assign text_char_o          = char_q;
  assign line_last_o          = last_q;
  assign transmission_ended_o = ended_q;

  `BLR_NEVER(a_start_when_busy, req_i.start && (state_q != S_IDLE),
             "Request arrived while the emitter was busy.")
  `BLR_ASSERT(a_char_shape, out_valid_q && !ended_q |->
              (char_q == CHAR_NEWLINE && last_q) ||
              (char_q >= CHAR_ZERO && char_q <= CHAR_ZERO + 8'd9 && !last_q),
              "Emitted character is neither a digit nor a closing newline.")
  `BLR_ASSERT(a_marker_shape, out_valid_q && ended_q |-> char_q == CHAR_MARKER && last_q,
              "End marker beat is malformed.")
  `BLR_ASSERT(a_load_needs_slot, load |-> slot_free,
              "Output register overwritten while stalled.")

endmodule

`default_nettype wire

// ===== sv/block_length_decimal_reporter_unit.sv =====
// ----------------------------------------------------------------------------
// Block length decimal reporter unit
// Counts nonzero bytes between zero separators and reports each block length
// as decimal ASCII text ending in a newline; an empty block repeated ends the
// transmission with a single marker beat until restart.
// ----------------------------------------------------------------------------
// A nonzero data byte or a restart beat is taken without holding off input.
// A zero byte that closes a block starts a bit-serial conversion of the
// length, which holds off input while the length is shifted into BCD, then
// while each decimal digit position (ceil(COUNT_WIDTH * log10 2), leading
// positions included) and the newline are handled, and while the output is
// stalled. A zero byte that ends the transmission holds off input until the
// marker beat is loaded, which waits while the output is stalled. After the
// end, data bytes are taken and ignored until a restart beat clears the state.
`default_nettype none
`include "block_length_decimal_reporter_unit_defines.svh"

module block_length_decimal_reporter_unit
  import blr_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       action_i,
  input  wire logic [7:0] data_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      text_char_o,
  output logic            line_last_o,
  output logic            transmission_ended_o
);

  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   prev_empty_q, prev_empty_d;
  logic                   ended_q, ended_d;
  logic                   busy;
  logic                   accept;
  logic                   count_zero;
  emit_req_t              req;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;
  assign count_zero = (count_q == '0);

  always_comb begin
    count_d      = count_q;
    prev_empty_d = prev_empty_q;
    ended_d      = ended_q;
    req          = '0;
    if (accept) begin
      if (action_i) begin
        count_d      = '0;
        prev_empty_d = 1'b0;
        ended_d      = 1'b0;
      end else if (!ended_q) begin
        if (data_byte_i != 8'd0) begin
          if (count_q != '1) begin
            count_d = count_q + COUNT_WIDTH'(1);
          end
        end else if (prev_empty_q && count_zero) begin
          ended_d    = 1'b1;
          req.start  = 1'b1;
          req.marker = 1'b1;
        end else begin
          prev_empty_d = count_zero;
          count_d      = '0;
          req.start    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      prev_empty_q <= 1'b0;
      ended_q      <= 1'b0;
    end else begin
      count_q      <= count_d;
      prev_empty_q <= prev_empty_d;
      ended_q      <= ended_d;
    end
  end

  blr_dec_emit #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_emit (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .req_i                (req),
    .value_i              (count_q),
    .busy_o               (busy),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .text_char_o          (text_char_o),
    .line_last_o          (line_last_o),
    .transmission_ended_o (transmission_ended_o)
  );

  `BLR_NEVER(a_no_start_after_end, ended_q && req.start,
             "Block reported after the transmission ended.")
  `BLR_ASSERT(a_end_needs_empty, req.marker |-> prev_empty_q && count_zero,
              "End marker requested without an empty block before it.")
  `BLR_ASSERT(a_restart_clears, accept && action_i |=> count_q == '0 && !ended_q
              && !prev_empty_q, "Restart beat did not clear the state.")

endmodule

`default_nettype wire
